### sv/pcci_pkg.sv
// Shared types, constants and microcode ROM for the clamped-integral PID controller.
package pcci_pkg;

    localparam int PC_W       = 4;
    localparam int CNT_W      = 5;
    localparam int MUL_W      = 33;
    localparam int PROD_W     = 66;
    localparam int ACC_W      = 84;
    localparam int INTEG_W    = 48;
    localparam int LIMIT_W    = 47;
    localparam int INTEG_LO_W = 16;
    localparam int DATA_W     = 64;
    localparam int ADDR_W     = 6;
    localparam int IDX_LSB    = 3;

    typedef enum logic [2:0] {
        REG_TARGET = 3'd0,
        REG_PROP   = 3'd1,
        REG_INTEG  = 3'd2,
        REG_DERIV  = 3'd3,
        REG_LIMIT  = 3'd4
    } reg_idx_t;

    typedef enum logic [3:0] {
        OP_NONE        = 4'd0,
        OP_CAPTURE     = 4'd1,
        OP_SETUP       = 4'd2,
        OP_DIV         = 4'd3,
        OP_DERIV       = 4'd4,
        OP_INTEG_ADD   = 4'd5,
        OP_INTEG_CLAMP = 4'd6,
        OP_ACC_ADD     = 4'd7,
        OP_ACC_ADD_HI  = 4'd8,
        OP_EMIT        = 4'd9,
        OP_LOAD_STATE  = 4'd10
    } op_t;

    typedef enum logic [2:0] {
        MUL_NONE    = 3'd0,
        MUL_ERR_DT  = 3'd1,
        MUL_P_ERR   = 3'd2,
        MUL_D_DERIV = 3'd3,
        MUL_I_LO    = 3'd4,
        MUL_I_HI    = 3'd5
    } mul_sel_t;

    typedef enum logic [2:0] {
        COND_NEVER      = 3'd0,
        COND_ALWAYS     = 3'd1,
        COND_NO_WORD    = 3'd2,
        COND_RESET_ITEM = 3'd3,
        COND_DIV_BUSY   = 3'd4,
        COND_OUT_FREE   = 3'd5
    } cond_t;

    typedef struct packed {
        op_t              op;
        mul_sel_t         mul;
        cond_t            cond;
        logic [PC_W-1:0]  target;
    } ctrl_t;

    localparam logic [PC_W-1:0] PC_WAIT        = 4'd0;
    localparam logic [PC_W-1:0] PC_SETUP       = 4'd1;
    localparam logic [PC_W-1:0] PC_DIV         = 4'd2;
    localparam logic [PC_W-1:0] PC_DERIV       = 4'd3;
    localparam logic [PC_W-1:0] PC_INTEG_ADD   = 4'd4;
    localparam logic [PC_W-1:0] PC_INTEG_CLAMP = 4'd5;
    localparam logic [PC_W-1:0] PC_ACC_D       = 4'd6;
    localparam logic [PC_W-1:0] PC_ACC_ILO     = 4'd7;
    localparam logic [PC_W-1:0] PC_ACC_IHI     = 4'd8;
    localparam logic [PC_W-1:0] PC_EMIT        = 4'd9;
    localparam logic [PC_W-1:0] PC_EMIT_RETRY  = 4'd10;
    localparam logic [PC_W-1:0] PC_LOAD_STATE  = 4'd11;

    function automatic ctrl_t cw(input op_t o, input mul_sel_t m, input cond_t c,
                                 input logic [PC_W-1:0] t);
        ctrl_t w;
        w.op     = o;
        w.mul    = m;
        w.cond   = c;
        w.target = t;
        return w;
    endfunction

    // Control program: one word per step, jump to target when cond holds.
    function automatic ctrl_t microcode(input logic [PC_W-1:0] pc);
        ctrl_t w;
        case (pc)
            PC_WAIT:        w = cw(OP_CAPTURE,     MUL_NONE,    COND_NO_WORD,    PC_WAIT);
            PC_SETUP:       w = cw(OP_SETUP,       MUL_NONE,    COND_RESET_ITEM, PC_LOAD_STATE);
            PC_DIV:         w = cw(OP_DIV,         MUL_NONE,    COND_DIV_BUSY,   PC_DIV);
            PC_DERIV:       w = cw(OP_DERIV,       MUL_ERR_DT,  COND_NEVER,      PC_WAIT);
            PC_INTEG_ADD:   w = cw(OP_INTEG_ADD,   MUL_P_ERR,   COND_NEVER,      PC_WAIT);
            PC_INTEG_CLAMP: w = cw(OP_INTEG_CLAMP, MUL_D_DERIV, COND_NEVER,      PC_WAIT);
            PC_ACC_D:       w = cw(OP_ACC_ADD,     MUL_I_LO,    COND_NEVER,      PC_WAIT);
            PC_ACC_ILO:     w = cw(OP_ACC_ADD,     MUL_I_HI,    COND_NEVER,      PC_WAIT);
            PC_ACC_IHI:     w = cw(OP_ACC_ADD_HI,  MUL_NONE,    COND_NEVER,      PC_WAIT);
            PC_EMIT:        w = cw(OP_EMIT,        MUL_NONE,    COND_OUT_FREE,   PC_WAIT);
            PC_EMIT_RETRY:  w = cw(OP_NONE,        MUL_NONE,    COND_ALWAYS,     PC_EMIT);
            PC_LOAD_STATE:  w = cw(OP_LOAD_STATE,  MUL_NONE,    COND_ALWAYS,     PC_EMIT);
            default:        w = cw(OP_NONE,        MUL_NONE,    COND_ALWAYS,     PC_WAIT);
        endcase
        return w;
    endfunction

    // Clamp a wide signed value to +-lim.
    function automatic logic signed [INTEG_W-1:0] clamp_integ(
        input logic signed [PROD_W-1:0] v,
        input logic [LIMIT_W-1:0]       lim
    );
        logic signed [PROD_W-1:0] hi;
        logic signed [PROD_W-1:0] lo;
        hi = {{(PROD_W-LIMIT_W){1'b0}}, lim};
        lo = -hi;
        if (v > hi)
            return hi[INTEG_W-1:0];
        else if (v < lo)
            return lo[INTEG_W-1:0];
        else
            return v[INTEG_W-1:0];
    endfunction

endpackage

### sv/pid_controller_clamped_integral.sv
// Top level of the clamped-integral PID controller: microcoded sequencer and datapath.
//
//   channel   direction  handshake                  payload
//   sample    in         sample_valid/sample_stall  action, position, timestamp, integral_init
//   result    out        result_valid/result_stall  drive, zero_interval, saturated
//   config    in         APB psel/penable/pwrite    paddr, pwdata, prdata (64 bit)
//
// A tick word passes through setup, a one-bit-per-cycle restoring divide for the slope,
// the derivative, integral and accumulate steps and emit before the sequencer can take
// the next word. A reset word skips the divide and loads the loop state before emit.
// While a previous result is still held and result_stall is high, the sequencer waits at emit.
// Reset (rst_n low, asynchronous) clears the configuration registers, the loop state
// and the sequencer; no clearing pass is needed.
// The output register parts the two channels: a new sample word is taken while the
// last result still waits to be taken.
module pid_controller_clamped_integral #(
    parameter int GAIN_FRAC_BITS = 16
) (
    input  logic                              clk,
    input  logic                              rst_n,
    // configuration port
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [pcci_pkg::ADDR_W-1:0]       paddr,
    input  logic [pcci_pkg::DATA_W-1:0]       pwdata,
    output logic [pcci_pkg::DATA_W-1:0]       prdata,
    output logic                              pready,
    // sample channel
    input  logic                              sample_valid,
    output logic                              sample_stall,
    input  logic                              action,
    input  logic signed [31:0]                position,
    input  logic [31:0]                       timestamp,
    input  logic signed [47:0]                integral_init,
    // result channel
    output logic                              result_valid,
    input  logic                              result_stall,
    output logic signed [31:0]                drive,
    output logic                              zero_interval,
    output logic                              saturated
);
    import pcci_pkg::*;

    // configuration registers
    logic signed [31:0]        target_reg,     target_next;
    logic signed [31:0]        prop_gain_reg,  prop_gain_next;
    logic signed [31:0]        integ_gain_reg, integ_gain_next;
    logic signed [31:0]        deriv_gain_reg, deriv_gain_next;
    logic [LIMIT_W-1:0]        limit_reg,      limit_next;

    // loop state
    logic [31:0]               last_time_reg,  last_time_next;
    logic signed [INTEG_W-1:0] integ_reg,      integ_next;
    logic signed [31:0]        last_pos_reg,   last_pos_next;

    // sequencer
    logic [PC_W-1:0]           pc_reg,         pc_next;
    ctrl_t                     ctrl;
    logic                      take_jump;

    // captured sample word
    logic                      action_reg,     action_next;
    logic signed [31:0]        pos_reg,        pos_next;
    logic [31:0]               ts_reg,         ts_next;
    logic signed [INTEG_W-1:0] init_reg,       init_next;

    // datapath working registers
    logic signed [MUL_W-1:0]   err_reg,        err_next;
    logic [31:0]               dt_reg,         dt_next;
    logic                      neg_reg,        neg_next;
    logic                      zi_reg,         zi_next;
    logic [31:0]               rem_reg,        rem_next;
    logic [31:0]               quo_reg,        quo_next;
    logic [CNT_W-1:0]          cnt_reg,        cnt_next;
    logic signed [MUL_W-1:0]   deriv_reg,      deriv_next;
    logic signed [PROD_W-1:0]  prod_reg,       prod_next;
    logic signed [PROD_W-1:0]  sum_reg,        sum_next;
    logic signed [ACC_W-1:0]   acc_reg,        acc_next;

    // output register
    logic                      result_valid_reg, result_valid_next;
    logic signed [31:0]        drive_reg,        drive_next;
    logic                      zi_out_reg,       zi_out_next;
    logic                      sat_out_reg,      sat_out_next;

    // combinational helpers
    logic                      cfg_write;
    logic [IDX_LSB-1:0]        cfg_idx;
    logic signed [MUL_W-1:0]   err_calc;
    logic signed [MUL_W-1:0]   diff_calc;
    logic signed [MUL_W-1:0]   diff_mag;
    logic [31:0]               dt_calc;
    logic [32:0]               div_trial;
    logic signed [MUL_W-1:0]   quo_ext;
    logic signed [MUL_W-1:0]   mul_a;
    logic signed [MUL_W-1:0]   mul_b;
    logic signed [PROD_W-1:0]  integ_ext;
    logic signed [ACC_W-1:0]   prod_ext;
    logic signed [ACC_W-1:0]   prod_hi_ext;
    logic signed [ACC_W-1:0]   acc_shifted;
    logic [ACC_W-32:0]         acc_upper;
    logic                      acc_ovf;
    logic                      out_free;
    logic                      emit;

    // ------------------------------------------------------------------
    // Configuration port: fixed-ready APB, 64-bit data, register i at 8*i
    // ------------------------------------------------------------------
    assign pready    = 1'b1;
    assign cfg_write = psel & penable & pwrite;
    assign cfg_idx   = paddr[ADDR_W-1:IDX_LSB];

    always_comb
    begin
        case (cfg_idx)
            REG_TARGET: prdata = {{(DATA_W-32){1'b0}}, target_reg};
            REG_PROP:   prdata = {{(DATA_W-32){1'b0}}, prop_gain_reg};
            REG_INTEG:  prdata = {{(DATA_W-32){1'b0}}, integ_gain_reg};
            REG_DERIV:  prdata = {{(DATA_W-32){1'b0}}, deriv_gain_reg};
            REG_LIMIT:  prdata = {{(DATA_W-LIMIT_W){1'b0}}, limit_reg};
            default:    prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Sequencer: fetch the control word, pick next step
    // ------------------------------------------------------------------
    assign ctrl         = microcode(pc_reg);
    assign sample_stall = (pc_reg != PC_WAIT);
    assign out_free     = !result_valid_reg || !result_stall;
    assign emit         = (ctrl.op == OP_EMIT) && out_free;

    always_comb
    begin
        case (ctrl.cond)
            COND_NEVER:      take_jump = 1'b0;
            COND_ALWAYS:     take_jump = 1'b1;
            COND_NO_WORD:    take_jump = !sample_valid;
            COND_RESET_ITEM: take_jump = action_reg;
            COND_DIV_BUSY:   take_jump = (cnt_reg != {CNT_W{1'b1}});
            COND_OUT_FREE:   take_jump = out_free;
            default:         take_jump = 1'b0;
        endcase
        pc_next = take_jump ? ctrl.target : pc_reg + 1'b1;
    end

    // ------------------------------------------------------------------
    // Datapath arithmetic
    // ------------------------------------------------------------------
    assign err_calc  = {target_reg[31], target_reg} - {pos_reg[31], pos_reg};
    assign diff_calc = {pos_reg[31], pos_reg} - {last_pos_reg[31], last_pos_reg};
    assign diff_mag  = diff_calc[MUL_W-1] ? -diff_calc : diff_calc;
    assign dt_calc   = ts_reg - last_time_reg;

    // one restoring step: shift in the next dividend bit, try to subtract dt
    assign div_trial = {rem_reg, quo_reg[31]} - {1'b0, dt_reg};
    assign quo_ext   = {1'b0, quo_reg};

    // shared 33x33 signed multiplier, product registered
    always_comb
    begin
        case (ctrl.mul)
            MUL_ERR_DT:
            begin
                mul_a = err_reg;
                mul_b = {1'b0, dt_reg};
            end
            MUL_P_ERR:
            begin
                mul_a = {prop_gain_reg[31], prop_gain_reg};
                mul_b = err_reg;
            end
            MUL_D_DERIV:
            begin
                mul_a = {deriv_gain_reg[31], deriv_gain_reg};
                mul_b = deriv_reg;
            end
            MUL_I_LO:
            begin
                mul_a = {integ_gain_reg[31], integ_gain_reg};
                mul_b = {{(MUL_W-INTEG_LO_W){1'b0}}, integ_reg[INTEG_LO_W-1:0]};
            end
            MUL_I_HI:
            begin
                mul_a = {integ_gain_reg[31], integ_gain_reg};
                mul_b = {integ_reg[INTEG_W-1], integ_reg[INTEG_W-1:INTEG_LO_W]};
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign prod_next   = mul_a * mul_b;
    assign integ_ext   = {{(PROD_W-INTEG_W){integ_reg[INTEG_W-1]}}, integ_reg};
    assign prod_ext    = {{(ACC_W-PROD_W){prod_reg[PROD_W-1]}}, prod_reg};
    assign prod_hi_ext = {{(ACC_W-PROD_W-INTEG_LO_W){prod_reg[PROD_W-1]}}, prod_reg,
                          {INTEG_LO_W{1'b0}}};

    // drop the gain fraction (floor), then saturate to 32 bits
    assign acc_shifted = acc_reg >>> GAIN_FRAC_BITS;
    assign acc_upper   = acc_shifted[ACC_W-1:31];
    assign acc_ovf     = !((&acc_upper) || !(|acc_upper));

    always_comb
    begin
        target_next     = target_reg;
        prop_gain_next  = prop_gain_reg;
        integ_gain_next = integ_gain_reg;
        deriv_gain_next = deriv_gain_reg;
        limit_next      = limit_reg;
        last_time_next  = last_time_reg;
        integ_next      = integ_reg;
        last_pos_next   = last_pos_reg;
        action_next     = action_reg;
        pos_next        = pos_reg;
        ts_next         = ts_reg;
        init_next       = init_reg;
        err_next        = err_reg;
        dt_next         = dt_reg;
        neg_next        = neg_reg;
        zi_next         = zi_reg;
        rem_next        = rem_reg;
        quo_next        = quo_reg;
        cnt_next        = cnt_reg;
        deriv_next      = deriv_reg;
        sum_next        = sum_reg;
        acc_next        = acc_reg;

        case (ctrl.op)
            OP_CAPTURE:
            begin
                if (sample_valid)
                begin
                    action_next = action;
                    pos_next    = position;
                    ts_next     = timestamp;
                    init_next   = integral_init;
                end
            end
            OP_SETUP:
            begin
                err_next = err_calc;
                dt_next  = dt_calc;
                neg_next = diff_calc[MUL_W-1];
                quo_next = diff_mag[31:0];
                rem_next = '0;
                cnt_next = '0;
                zi_next  = (dt_calc == '0);
            end
            OP_DIV:
            begin
                if (!div_trial[32])
                begin
                    rem_next = div_trial[31:0];
                    quo_next = {quo_reg[30:0], 1'b1};
                end
                else
                begin
                    rem_next = {rem_reg[30:0], quo_reg[31]};
                    quo_next = {quo_reg[30:0], 1'b0};
                end
                cnt_next = cnt_reg + 1'b1;
            end
            OP_DERIV:
            begin
                // truncate toward zero: divide magnitudes, restore sign
                if (zi_reg)
                    deriv_next = '0;
                else if (neg_reg)
                    deriv_next = -quo_ext;
                else
                    deriv_next = quo_ext;
                last_time_next = ts_reg;
                last_pos_next  = pos_reg;
            end
            OP_INTEG_ADD:
            begin
                sum_next = integ_ext + prod_reg;
            end
            OP_INTEG_CLAMP:
            begin
                integ_next = clamp_integ(sum_reg, limit_reg);
                acc_next   = prod_ext;
            end
            OP_ACC_ADD:
            begin
                acc_next = acc_reg + prod_ext;
            end
            OP_ACC_ADD_HI:
            begin
                acc_next = acc_reg + prod_hi_ext;
            end
            OP_LOAD_STATE:
            begin
                last_time_next = ts_reg;
                integ_next     = init_reg;
                last_pos_next  = pos_reg;
                acc_next       = '0;
                zi_next        = 1'b0;
            end
            default:
            begin
            end
        endcase

        // register writes must arrive only while the sequencer waits for a word; the block itself does not enforce this
        if (cfg_write)
        begin
            case (cfg_idx)
                REG_TARGET: target_next     = pwdata[31:0];
                REG_PROP:   prop_gain_next  = pwdata[31:0];
                REG_INTEG:  integ_gain_next = pwdata[31:0];
                REG_DERIV:  deriv_gain_next = pwdata[31:0];
                REG_LIMIT:
                begin
                    limit_next = pwdata[LIMIT_W-1:0];
                    integ_next = clamp_integ(integ_ext, pwdata[LIMIT_W-1:0]);
                end
                default:
                begin
                end
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Output register: load on emit, drop when the word is taken
    // ------------------------------------------------------------------
    always_comb
    begin
        result_valid_next = result_valid_reg;
        drive_next        = drive_reg;
        zi_out_next       = zi_out_reg;
        sat_out_next      = sat_out_reg;
        if (emit)
        begin
            result_valid_next = 1'b1;
            zi_out_next       = zi_reg;
            sat_out_next      = acc_ovf;
            if (!acc_ovf)
                drive_next = acc_shifted[31:0];
            else if (acc_shifted[ACC_W-1])
                drive_next = 32'sh8000_0000;
            else
                drive_next = 32'sh7FFF_FFFF;
        end
        else if (!result_stall)
        begin
            result_valid_next = 1'b0;
        end
    end

    assign result_valid  = result_valid_reg;
    assign drive         = drive_reg;
    assign zero_interval = zi_out_reg;
    assign saturated     = sat_out_reg;

    // control and architectural state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg           <= PC_WAIT;
            result_valid_reg <= 1'b0;
            target_reg       <= '0;
            prop_gain_reg    <= '0;
            integ_gain_reg   <= '0;
            deriv_gain_reg   <= '0;
            limit_reg        <= '0;
            last_time_reg    <= '0;
            integ_reg        <= '0;
            last_pos_reg     <= '0;
        end
        else
        begin
            pc_reg           <= pc_next;
            result_valid_reg <= result_valid_next;
            target_reg       <= target_next;
            prop_gain_reg    <= prop_gain_next;
            integ_gain_reg   <= integ_gain_next;
            deriv_gain_reg   <= deriv_gain_next;
            limit_reg        <= limit_next;
            last_time_reg    <= last_time_next;
            integ_reg        <= integ_next;
            last_pos_reg     <= last_pos_next;
        end
    end

    // payload and working registers
    always_ff @(posedge clk)
    begin
        action_reg  <= action_next;
        pos_reg     <= pos_next;
        ts_reg      <= ts_next;
        init_reg    <= init_next;
        err_reg     <= err_next;
        dt_reg      <= dt_next;
        neg_reg     <= neg_next;
        zi_reg      <= zi_next;
        rem_reg     <= rem_next;
        quo_reg     <= quo_next;
        cnt_reg     <= cnt_next;
        deriv_reg   <= deriv_next;
        prod_reg    <= prod_next;
        sum_reg     <= sum_next;
        acc_reg     <= acc_next;
        drive_reg   <= drive_next;
        zi_out_reg  <= zi_out_next;
        sat_out_reg <= sat_out_next;
    end

`ifndef NO_ASSERTIONS
    // the clamped integral is within the limit once the integral products start
    a_integ_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        (pc_reg == PC_ACC_D) |->
            (integ_reg <= $signed({1'b0, limit_reg})) &&
            (integ_reg >= -$signed({1'b0, limit_reg})))
        else $error("integral outside limit after clamp");

    // restoring divide keeps the partial remainder below the divisor
    a_rem_below_dt: assert property (@(posedge clk) disable iff (!rst_n)
        (pc_reg == PC_DIV) && (dt_reg != '0) |-> (rem_reg < dt_reg))
        else $error("divider remainder not below interval");

    // a new result word only appears out of the emit step
    a_emit_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid_reg) |-> ($past(pc_reg) == PC_EMIT))
        else $error("result word raised outside emit step");
`endif

endmodule

### bench/testbench.sv
// Self-checking bench for the clamped-integral PID controller: directed table, then random words.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import pcci_pkg::*;

    localparam int FRAC_BITS   = 16;
    localparam int RESET_CYCLES = 12;
    localparam int SETTLE      = 8;     // idle cycles after the last result before a write
    localparam int HOLD_CYCLES = 400;   // long receiver hold-off, far beyond one tick word
    localparam int DEAD_LIMIT  = 4000;  // cycles with no handshake before giving up
    localparam int PHASES      = 8;
    localparam int PHASE_WORDS = 200;
    localparam int MAX_REPORTS = 30;

    localparam logic ACT_TICK = 1'b0;
    localparam logic ACT_LOAD = 1'b1;

    localparam logic signed [127:0] INC_CAP   = 128'sh4000_0000_0000_0000;
    localparam logic signed [127:0] DRIVE_MAX = 128'sh7FFF_FFFF;
    localparam logic signed [127:0] DRIVE_MIN = -DRIVE_MAX - 1;

    typedef struct packed {
        logic               action;
        logic signed [31:0] position;
        logic [31:0]        timestamp;
        logic signed [47:0] integral_init;
    } sample_t;

    typedef struct packed {
        logic signed [31:0] drive;
        logic               zero_interval;
        logic               saturated;
    } result_t;

    typedef enum logic {ROW_WORD, ROW_REG} row_kind_t;

    typedef struct {
        row_kind_t   kind;
        reg_idx_t    idx;
        logic [63:0] value;
        sample_t     word;
        logic        typed;
        result_t     want;
    } row_t;

    logic                 clk;
    logic                 rst_n;
    logic                 psel;
    logic                 penable;
    logic                 pwrite;
    logic [ADDR_W-1:0]    paddr;
    logic [DATA_W-1:0]    pwdata;
    logic [DATA_W-1:0]    prdata;
    logic                 pready;
    logic                 sample_valid;
    logic                 sample_stall;
    logic                 action;
    logic signed [31:0]   position;
    logic [31:0]          timestamp;
    logic signed [47:0]   integral_init;
    logic                 result_valid;
    logic                 result_stall;
    logic signed [31:0]   drive;
    logic                 zero_interval;
    logic                 saturated;

    // Controller state as the bench expects it
    logic signed [31:0]   set_point;
    logic signed [31:0]   gain_p;
    logic signed [31:0]   gain_i;
    logic signed [31:0]   gain_d;
    logic [46:0]          integ_bound;
    logic [31:0]          prev_time;
    logic signed [47:0]   integ_acc;
    logic signed [31:0]   prev_pos;

    result_t awaited_results[$];
    row_t    stim_rows[$];

    int      mismatches;
    int      reports;
    int      tick_words;
    int      load_words;
    int      zero_iv_seen;
    int      sat_seen;
    int      reg_writes;
    int      results_checked;
    int      dead_cycles;
    int      hold_requests;
    int      holds_started;
    int      hold_left;
    int      burst_left;
    bit      steady;    // set in the last phase: no idling on either side

    logic [31:0]        gen_time;
    logic signed [31:0] gen_pos;

    pid_controller_clamped_integral #(
        .GAIN_FRAC_BITS (FRAC_BITS)
    ) i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .sample_valid  (sample_valid),
        .sample_stall  (sample_stall),
        .action        (action),
        .position      (position),
        .timestamp     (timestamp),
        .integral_init (integral_init),
        .result_valid  (result_valid),
        .result_stall  (result_stall),
        .drive         (drive),
        .zero_interval (zero_interval),
        .saturated     (saturated)
    );

    initial clk = 1'b0;
    always #1 clk = ~clk;

    // Clamp a wide integral value to +-integ_bound, keep the 48-bit stored form
    function automatic logic signed [47:0] bound_integral(input logic signed [127:0] v);
        logic signed [127:0] lim_w;
        lim_w = {81'd0, integ_bound};
        if (v > lim_w)
            v = lim_w;
        else if (v < -lim_w)
            v = -lim_w;
        return v[47:0];
    endfunction

    // Advance the expected loop state by one word and form its result.
    // Everything is carried at 128 bits so products and sums stay exact.
    task automatic regulate(input sample_t w, output result_t r);
        logic signed [31:0]  pos;
        logic [31:0]         dt;
        logic signed [127:0] err;
        logic signed [127:0] dt_w;
        logic signed [127:0] slope;
        logic signed [127:0] mag;
        logic signed [127:0] inc;
        logic signed [127:0] acc;
        logic signed [127:0] shifted;
        pos = w.position;
        r   = '0;
        if (w.action == ACT_LOAD) begin
            // Load the loop state as given; the integral is not clamped here
            prev_time = w.timestamp;
            integ_acc = w.integral_init;
            prev_pos  = pos;
        end
        else begin
            err  = set_point - pos;
            dt   = w.timestamp - prev_time;
            dt_w = {96'd0, dt};
            if (dt == 32'd0) begin
                slope = '0;
                r.zero_interval = 1'b1;
            end
            else begin
                slope = pos - prev_pos;
                slope = slope / dt_w;   // truncates toward zero
            end
            // Cap the increment magnitude at 2^62; the clamp outcome is unchanged
            mag = (err < 0) ? -err : err;
            mag = mag * dt_w;
            if (mag > INC_CAP)
                mag = INC_CAP;
            inc = (err < 0) ? -mag : mag;
            integ_acc = bound_integral(integ_acc + inc);

            acc = gain_p * err + gain_i * integ_acc + gain_d * slope;
            shifted = acc >>> FRAC_BITS;
            if (shifted > DRIVE_MAX) begin
                r.drive = DRIVE_MAX[31:0];
                r.saturated = 1'b1;
            end
            else if (shifted < DRIVE_MIN) begin
                r.drive = DRIVE_MIN[31:0];
                r.saturated = 1'b1;
            end
            else begin
                r.drive = shifted[31:0];
            end
            prev_time = w.timestamp;
            prev_pos  = pos;
        end
    endtask

    // Drop valid and keep the sender idle (n >= 1, so valid never toggles within a step)
    task automatic idle_sender(input int n);
        sample_valid <= 1'b0;
        repeat (n) @(posedge clk);
    endtask

    // Random gap on the sample side, none in the steady phase
    task automatic maybe_gap();
        if (!steady && $urandom_range(0, 3) == 0)
            idle_sender($urandom_range(1, 5));
    endtask

    // Hold off the sender until every expected result has come, then let the block settle
    task automatic wait_drained();
        idle_sender(1);
        while (awaited_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    // Offer one word and hold it until accepted; then record what it should produce
    task automatic offer_word(input sample_t w, input logic typed, input result_t want);
        result_t r;
        sample_valid  <= 1'b1;
        action        <= w.action;
        position      <= w.position;
        timestamp     <= w.timestamp;
        integral_init <= w.integral_init;
        @(posedge clk);
        while (sample_stall)
            @(posedge clk);
        regulate(w, r);
        if (typed)
            r = want;
        awaited_results.push_back(r);
        if (w.action == ACT_LOAD)
            load_words++;
        else
            tick_words++;
        zero_iv_seen += r.zero_interval;
        sat_seen     += r.saturated;
    endtask

    // APB write: setup phase, access phase, then idle
    task automatic write_reg(input reg_idx_t idx, input logic [63:0] v);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_W'(idx) << IDX_LSB;
        pwdata  <= v;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
        case (idx)
            REG_TARGET: set_point = v[31:0];
            REG_PROP:   gain_p    = v[31:0];
            REG_INTEG:  gain_i    = v[31:0];
            REG_DERIV:  gain_d    = v[31:0];
            REG_LIMIT:
            begin
                integ_bound = v[46:0];
                integ_acc   = bound_integral(integ_acc);
            end
            default: ;
        endcase
        reg_writes++;
    endtask

    function automatic void add_word(input logic a, input logic signed [31:0] pos,
                                     input logic [31:0] ts, input logic signed [47:0] init,
                                     input logic typed, input logic signed [31:0] drv,
                                     input logic zi, input logic sat);
        row_t row;
        row.kind  = ROW_WORD;
        row.idx   = REG_TARGET;
        row.value = '0;
        row.word  = '{a, pos, ts, init};
        row.typed = typed;
        row.want  = '{drv, zi, sat};
        stim_rows.push_back(row);
    endfunction

    function automatic void add_reg(input reg_idx_t idx, input logic [63:0] v);
        row_t row;
        row.kind  = ROW_REG;
        row.idx   = idx;
        row.value = v;
        row.word  = '0;
        row.typed = 1'b0;
        row.want  = '0;
        stim_rows.push_back(row);
    endfunction

    // Gain or setpoint: extremes, small values around zero, or anything
    function automatic logic [63:0] pick_gain();
        logic [31:0] g;
        case ($urandom_range(0, 7))
            0:       g = 32'h7FFF_FFFF;
            1:       g = 32'h8000_0000;
            2:       g = 32'h0;
            3, 4, 5: g = 32'($urandom_range(0, 524288)) - 32'd262144;
            default: g = $urandom;
        endcase
        // upper half is don't-care for 32-bit registers
        return {$urandom, g};
    endfunction

    function automatic logic [63:0] pick_limit();
        logic [63:0] raw;
        raw = {$urandom, $urandom};
        case ($urandom_range(0, 7))
            0:       raw[46:0] = '0;
            1:       raw[46:0] = '1;
            2, 3, 4: raw[46:0] = 47'($urandom_range(0, 100000));
            default: ;
        endcase
        return raw;
    endfunction

    task automatic shuffle_settings();
        write_reg(REG_TARGET, pick_gain());
        write_reg(REG_PROP,   pick_gain());
        write_reg(REG_INTEG,  pick_gain());
        write_reg(REG_DERIV,  pick_gain());
        write_reg(REG_LIMIT,  pick_limit());
    endtask

    // Mostly a plausible sample stream (small steps in time and position),
    // with wraps, zero intervals, extremes and loads mixed in
    task automatic next_word(output sample_t w);
        logic [63:0] raw;
        raw = {$urandom, $urandom};
        case ($urandom_range(0, 9))
            0:             gen_time = gen_time;
            1, 2, 3, 4, 5: gen_time = gen_time + 32'($urandom_range(1, 1000));
            6, 7:          gen_time = $urandom;
            8:             gen_time = gen_time + 32'($urandom_range(1, 16));
            default:       gen_time = gen_time - 32'($urandom_range(1, 16));
        endcase
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: gen_pos = gen_pos + 32'($urandom_range(0, 2000)) - 32'd1000;
            5, 6, 7:       gen_pos = $urandom;
            8:             gen_pos = 32'sh8000_0000;
            default:       gen_pos = 32'sh7FFF_FFFF;
        endcase
        w.action    = ($urandom_range(0, 11) == 0) ? ACT_LOAD : ACT_TICK;
        w.position  = gen_pos;
        w.timestamp = gen_time;
        if ($urandom_range(0, 1) == 0)
            w.integral_init = raw[47:0];
        else
            w.integral_init = 48'($urandom_range(0, 200000)) - 48'd100000;
    endtask

    // Receiver: random stall bursts, plus the long hold-off on request
    always @(posedge clk) begin
        if (hold_left > 0) begin
            result_stall <= 1'b1;
            hold_left    <= hold_left - 1;
        end
        else if (holds_started != hold_requests) begin
            holds_started <= holds_started + 1;
            hold_left     <= HOLD_CYCLES - 1;
            result_stall  <= 1'b1;
        end
        else if (burst_left > 0) begin
            result_stall <= 1'b1;
            burst_left   <= burst_left - 1;
        end
        else if (!steady && $urandom_range(0, 7) == 0) begin
            result_stall <= 1'b1;
            burst_left   <= $urandom_range(0, 4);
        end
        else begin
            result_stall <= 1'b0;
        end
    end

    // Compare each taken result with the oldest expectation
    always @(posedge clk) begin
        if (rst_n && result_valid && !result_stall) begin
            if (awaited_results.size() == 0) begin
                mismatches++;
                if (reports < MAX_REPORTS)
                    $display("%0t: result with nothing pending: drive %0d zi %0b sat %0b",
                             $time, drive, zero_interval, saturated);
                reports++;
            end
            else begin
                check_result(awaited_results.pop_front());
            end
        end
    end

    task automatic check_result(input result_t want);
        results_checked++;
        if (drive !== want.drive || zero_interval !== want.zero_interval
            || saturated !== want.saturated) begin
            mismatches++;
            if (drive !== want.drive && reports < MAX_REPORTS)
                $display("%0t: drive expected %0d actual %0d", $time, want.drive, drive);
            if (zero_interval !== want.zero_interval && reports < MAX_REPORTS)
                $display("%0t: zero_interval expected %0b actual %0b",
                         $time, want.zero_interval, zero_interval);
            if (saturated !== want.saturated && reports < MAX_REPORTS)
                $display("%0t: saturated expected %0b actual %0b",
                         $time, want.saturated, saturated);
            reports++;
        end
    endtask

    // Watchdog: any handshake or register access counts as progress
    always @(posedge clk) begin
        if (!rst_n || (sample_valid && !sample_stall) || (result_valid && !result_stall)
            || psel)
            dead_cycles <= 0;
        else if (dead_cycles >= DEAD_LIMIT) begin
            $display("%0t: no progress for %0d cycles, %0d results outstanding",
                     $time, dead_cycles, awaited_results.size());
            $display("FAILURE");
            $finish;
        end
        else
            dead_cycles <= dead_cycles + 1;
    end

    initial begin
        rst_n         = 1'b0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        sample_valid  = 1'b0;
        action        = ACT_TICK;
        position      = '0;
        timestamp     = '0;
        integral_init = '0;
        result_stall  = 1'b0;
        set_point     = '0;
        gain_p        = '0;
        gain_i        = '0;
        gain_d        = '0;
        integ_bound   = '0;
        prev_time     = '0;
        integ_acc     = '0;
        prev_pos      = '0;
        gen_time      = '0;
        gen_pos       = '0;
        mismatches    = 0;
        reports       = 0;
        tick_words    = 0;
        load_words    = 0;
        zero_iv_seen  = 0;
        sat_seen      = 0;
        reg_writes    = 0;
        results_checked = 0;
        dead_cycles   = 0;
        hold_requests = 0;
        holds_started = 0;
        hold_left     = 0;
        burst_left    = 0;
        steady        = 1'b0;

        // Directed table. Typed results only where obvious: reset gains give
        // zero drive, loads answer zero, and full-scale gains pin the rails.
        add_word(ACT_TICK, 32'sd0, 32'h0, 48'sd0, 1'b1, 32'sd0, 1'b1, 1'b0);
        add_word(ACT_TICK, 32'sh7FFF_FFFF, 32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF,
                 1'b1, 32'sd0, 1'b0, 1'b0);
        add_word(ACT_LOAD, 32'sh8000_0000, 32'h1234_5678, 48'sh7FFF_FFFF_FFFF,
                 1'b1, 32'sd0, 1'b0, 1'b0);
        add_word(ACT_TICK, 32'sd0, 32'h1234_5678, 48'sd0, 1'b1, 32'sd0, 1'b1, 1'b0);
        add_reg(REG_TARGET, 64'h7FFF_FFFF);
        add_reg(REG_PROP, 64'h7FFF_FFFF);
        add_reg(REG_LIMIT, 64'h7FFF_FFFF_FFFF);
        // widest error at top gain: clip high
        add_word(ACT_TICK, 32'sh8000_0000, 32'h1234_5679, 48'sd0,
                 1'b1, 32'sh7FFF_FFFF, 1'b0, 1'b1);
        add_reg(REG_PROP, 64'h8000_0000);
        add_word(ACT_TICK, 32'sh8000_0000, 32'h1234_567A, 48'sd0,
                 1'b1, 32'sh8000_0000, 1'b0, 1'b1);
        add_reg(REG_TARGET, 64'h0);
        add_reg(REG_PROP, 64'h1_0000);
        add_reg(REG_INTEG, 64'h1_0000);
        add_reg(REG_DERIV, 64'hFFFF_0000);
        add_reg(REG_LIMIT, 64'd1000);   // also clamps the integral built up above
        add_word(ACT_TICK, 32'sd1000, 32'h1234_5684, 48'sd0, 1'b0, 32'sd0, 1'b0, 1'b0);
        add_word(ACT_TICK, -32'sd5, 32'h1234_568E, 48'sd0, 1'b0, 32'sd0, 1'b0, 1'b0);
        // same timestamp: zero interval
        add_word(ACT_TICK, 32'sd100, 32'h1234_568E, 48'sd0, 1'b0, 32'sd0, 1'b0, 1'b0);
        // dt of 2^32-1 with a 2^31 error: increment exceeds 2^62
        add_word(ACT_TICK, 32'sh8000_0000, 32'h1234_568D, 48'sd0, 1'b0, 32'sd0, 1'b0, 1'b0);
        add_word(ACT_TICK, 32'sh7FFF_FFFF, 32'h1234_568C, 48'sd0, 1'b0, 32'sd0, 1'b0, 1'b0);
        // zero limit holds the integral at zero, even after an unclamped load
        add_reg(REG_LIMIT, 64'h0);
        add_word(ACT_TICK, 32'sd3, 32'h1234_5691, 48'sd0, 1'b0, 32'sd0, 1'b0, 1'b0);
        add_word(ACT_LOAD, 32'sh7FFF_FFFF, 32'h0, 48'sh8000_0000_0000,
                 1'b1, 32'sd0, 1'b0, 1'b0);
        add_word(ACT_TICK, 32'sd0, 32'h0, 48'sd0, 1'b0, 32'sd0, 1'b0, 1'b0);
        add_reg(REG_LIMIT, 64'h7FFF_FFFF_FFFF);
        add_reg(REG_INTEG, 64'h7FFF_FFFF);
        add_word(ACT_LOAD, 32'sd0, 32'd100, 48'sh7FFF_FFFF_FFFF, 1'b1, 32'sd0, 1'b0, 1'b0);
        add_word(ACT_TICK, 32'sd0, 32'd100, 48'sd0, 1'b0, 32'sd0, 1'b0, 1'b0);
        // negative slope truncates toward zero
        add_reg(REG_INTEG, 64'h0);
        add_reg(REG_DERIV, 64'h1_0000);
        add_word(ACT_TICK, -32'sd7, 32'd102, 48'sd0, 1'b0, 32'sd0, 1'b0, 1'b0);
        // limit write shrinks a loaded integral
        add_word(ACT_LOAD, 32'sd0, 32'd200, 48'sh0001_2345_6789, 1'b1, 32'sd0, 1'b0, 1'b0);
        add_reg(REG_LIMIT, 64'd5);
        add_reg(REG_INTEG, 64'h1_0000);
        add_word(ACT_TICK, 32'sd0, 32'd200, 48'sd0, 1'b0, 32'sd0, 1'b0, 1'b0);

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Walk the table; registers change only once the block has gone quiet
        foreach (stim_rows[k]) begin
            if (stim_rows[k].kind == ROW_REG) begin
                wait_drained();
                write_reg(stim_rows[k].idx, stim_rows[k].value);
            end
            else begin
                offer_word(stim_rows[k].word, stim_rows[k].typed, stim_rows[k].want);
                maybe_gap();
            end
        end

        // Random phases, each under fresh settings
        gen_time = prev_time;
        gen_pos  = prev_pos;
        for (int phase = 0; phase < PHASES; phase++) begin
            sample_t w;
            wait_drained();
            shuffle_settings();
            if (phase == PHASES - 1)
                steady = 1'b1;
            for (int n = 0; n < PHASE_WORDS; n++) begin
                // long receiver hold-off while the sender keeps offering
                if (phase == 3 && n == 20)
                    hold_requests++;
                // sender pause until the block has answered everything
                if (phase == 5 && n == 100)
                    wait_drained();
                next_word(w);
                offer_word(w, 1'b0, '0);
                maybe_gap();
            end
        end

        wait_drained();
        repeat (60) @(posedge clk);

        $display("Covered %0d tick and %0d load words over %0d register writes.",
                 tick_words, load_words, reg_writes);
        $display("Checked %0d results: %0d zero-interval, %0d saturated, %0d mismatched.",
                 results_checked, zero_iv_seen, sat_seen, mismatches);
        if (mismatches == 0 && awaited_results.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

### files.f
sv/pcci_pkg.sv
sv/pid_controller_clamped_integral.sv
bench/testbench.sv
